// File: src/lpkt_pkg.sv
// Package for the linear-probing key table.
// Holds the key layout, the hash datapath sizes and the result status codes.
// No dependencies.
`default_nettype none

package lpkt_pkg;

    // Number of slots in the table by default.
    localparam int TABLE_SLOTS_DEF = 31;

    // Key layout: nine bytes, byte 0 in the top byte.
    localparam int KEY_BYTES = 9;
    localparam int KEY_W     = 72;
    localparam int FIRST_W   = 64;
    localparam int NINTH_W   = 7;

    // The byte sum of a trimmed key is at most 8 * 255 + 127, which needs 12 bits.
    // The remainder is taken by a reciprocal multiplication and then a subtraction.
    localparam int SUM_W      = 12;
    localparam int HASH_STEPS = 2;
    localparam int STEP_W     = 1;

    // Result fields.
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;

endpackage

`default_nettype wire

// File: src/linear_probe_key_table_top.sv
// Top level of the linear-probing key table: key store, used-bit store and sequencer.
// Depends on lpkt_pkg for the key layout, hash sizes and status codes.
// Memories are synchronous, with registered read data.
`default_nettype none

// A request (insert or search of one key) is taken when start is high and busy
// is low. Every request gives exactly one result, shown on o_status and o_slot
// for a single cycle while o_valid is high; the result cannot be held off, so
// it must be captured in that cycle. A request is worked in order: the home
// slot by a reciprocal multiplication and then a subtraction, then one memory
// read per probed slot (1 to TABLE_SLOTS slots), then the strobe cycle, in
// which the next request may already be taken. After reset a clearing pass
// over the used-bit memory, which clears each slot in turn, keeps busy high.
module linear_probe_key_table_top
    import lpkt_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_req_type,
    input  wire logic [FIRST_W-1:0]  i_key_first_eight,
    input  wire logic [NINTH_W-1:0]  i_key_ninth_byte,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W-1:0]        o_slot
);

    localparam int IDX_W    = $clog2(TABLE_SLOTS);
    localparam int RECIP_SH = SUM_W + $clog2(TABLE_SLOTS);
    localparam int RECIP_W  = SUM_W + 2;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + TABLE_SLOTS - 1) / TABLE_SLOTS);
    localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr, n_clr;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [IDX_W-1:0]    r_home, n_home;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic                r_search, n_search;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;

    // Memory ports.
    logic [KEY_W-1:0]    r_key_mem [TABLE_SLOTS];
    logic                r_used_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]    r_key_rd;
    logic                r_used_rd;
    logic [IDX_W-1:0]    rd_addr;
    logic                key_we;
    logic                used_we;
    logic [IDX_W-1:0]    used_wa;
    logic                used_wd;

    logic                accept;
    logic [KEY_W-1:0]    trim_key;
    logic [SUM_W-1:0]    trim_sum;
    logic [PROD_W-1:0]   recip_prod;
    logic [PROD_W-1:0]   recip_quo;
    logic [SUM_W-1:0]    quo_mul;
    logic [SUM_W-1:0]    hash_rem;
    logic [IDX_W-1:0]    next_cur;
    logic                key_match;
    logic [WIDE_W-1:0]   cur_wide;

    assign accept = start && !busy;

    // Trim the key at its first zero byte and sum the kept bytes.
    always_comb begin
        logic       ended;
        logic [7:0] v;
        ended    = 1'b0;
        trim_key = '0;
        trim_sum = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < 8) begin
                v = i_key_first_eight[FIRST_W-1-8*i -: 8];
            end else begin
                v = {1'b0, i_key_ninth_byte};
            end
            if (i >= KEY_BYTES || v == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                trim_key[KEY_W-1-8*i -: 8] = v;
                trim_sum = trim_sum + SUM_W'(v);
            end
        end
    end

    // Home slot: the quotient by the slot count comes from a multiplication by
    // its scaled reciprocal, exact for every byte sum; the next cycle subtracts
    // quotient times slot count to leave the remainder.
    assign recip_prod = {{RECIP_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, RECIP};
    assign recip_quo  = recip_prod >> RECIP_SH;
    assign quo_mul    = r_quo * SUM_W'(TABLE_SLOTS);
    assign hash_rem   = r_sum - quo_mul;

    // Probe bookkeeping for the slot whose data is on the read port.
    assign next_cur  = (r_cur == LAST_IDX) ? '0 : r_cur + IDX_W'(1);
    assign key_match = (r_key_rd == r_key);
    assign cur_wide  = WIDE_W'(r_cur);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_step   = r_step;
        n_sum    = r_sum;
        n_quo    = r_quo;
        n_home   = r_home;
        n_cur    = r_cur;
        n_search = r_search;
        n_key    = r_key;
        n_valid  = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        rd_addr  = r_cur;
        key_we   = 1'b0;
        used_we  = 1'b0;
        used_wa  = r_cur;
        used_wd  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                used_we = 1'b1;
                used_wa = r_clr;
                used_wd = 1'b0;
                n_clr   = r_clr + IDX_W'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_search = i_req_type;
                    n_key    = trim_key;
                    n_sum    = trim_sum;
                    n_step   = STEP_W'(HASH_STEPS - 1);
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                n_step = r_step - STEP_W'(1);
                if (r_step != '0) begin
                    n_quo = recip_quo[SUM_W-1:0];
                end else begin
                    // The remainder is the home slot: start its read now.
                    rd_addr = hash_rem[IDX_W-1:0];
                    n_home  = hash_rem[IDX_W-1:0];
                    n_cur   = hash_rem[IDX_W-1:0];
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                rd_addr = next_cur;
                if (!r_used_rd) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_search) begin
                        n_status = ST_ABSENT;
                        n_slot   = '0;
                    end else begin
                        key_we   = 1'b1;
                        used_we  = 1'b1;
                        used_wa  = r_cur;
                        used_wd  = 1'b1;
                        n_status = ST_INSERTED;
                        n_slot   = cur_wide[SLOT_W-1:0];
                    end
                end else if (key_match) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    n_status = r_search ? ST_FOUND : ST_PRESENT;
                    n_slot   = cur_wide[SLOT_W-1:0];
                end else if (next_cur == r_home) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    n_status = r_search ? ST_ABSENT : ST_FULL;
                    n_slot   = '0;
                end else begin
                    n_cur = next_cur;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_quo    <= n_quo;
        r_home   <= n_home;
        r_cur    <= n_cur;
        r_search <= n_search;
        r_key    <= n_key;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    // Key store: written on a successful insert, read every cycle.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_cur] <= r_key;
        end
        r_key_rd <= r_key_mem[rd_addr];
    end

    // Used-bit store: cleared after reset, set on a successful insert.
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_wa] <= used_wd;
        end
        r_used_rd <= r_used_mem[rd_addr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    // A result strobe lasts one cycle only.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // Every result comes straight out of a probe.
    a_result_from_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_PROBE))
        else $error("result strobe without a preceding probe");

    // An accepted request always begins with the home slot calculation.
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_HASH))
        else $error("accepted request did not start hashing");

    // Table full and not found carry slot zero.
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL || o_status == ST_ABSENT)) |-> (o_slot == '0))
        else $error("miss result with a non-zero slot");

    // The probe index stays inside the table.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_cur <= LAST_IDX && r_home <= LAST_IDX))
        else $error("probe index beyond the table");

endmodule

`default_nettype wire
